>>> design/rtmp_pkg.sv
// Package: shared types, constants and helpers for the recurrence-term block.
`default_nettype none
package rtmp_pkg;

  localparam int unsigned ELEM_W = 14;
  localparam int unsigned SUM_W = 29;
  localparam int unsigned RED_W = 16;
  localparam logic [ELEM_W-1:0] MODULUS = 14'd10007;
  // floor(2^29 / 10007); estimated quotient is low by at most one
  localparam logic [RED_W-1:0] RECIP = 16'd53649;
  localparam int unsigned RECIP_SHIFT = 29;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [2:0][ELEM_W-1:0] row_t;

  typedef struct packed {
    logic init;
    logic snap;
    logic mac;
    logic mac_first;
    logic red1;
    logic red2;
    logic red3;
    logic base;
  } rtmp_ctl_t;

  // Reduce a value below three times the modulus.
  function automatic elem_t mod_fix(input logic [RED_W-1:0] x);
    logic [RED_W-1:0] y;
    y = x;
    if (y >= RED_W'(MODULUS)) y = y - RED_W'(MODULUS);
    if (y >= RED_W'(MODULUS)) y = y - RED_W'(MODULUS);
    return y[ELEM_W-1:0];
  endfunction

  // (i + t) mod 3 for i, t in 0..2
  function automatic logic [1:0] rot3(input logic [1:0] i, input logic [1:0] t);
    logic [2:0] s;
    s = {1'b0, i} + {1'b0, t};
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/rtmp_cell.sv
// One row cell: holds a row of the power matrix and a rotating copy of a row.
`default_nettype none
module rtmp_cell (
  input  wire                   clk,
  input  rtmp_pkg::rtmp_ctl_t   ctl,
  input  rtmp_pkg::row_t        init_row,
  input  wire [1:0]             ksel,
  input  rtmp_pkg::row_t        pass_in,
  output rtmp_pkg::row_t        pass_out,
  output rtmp_pkg::row_t        acc_row
);
  import rtmp_pkg::*;

  row_t acc_r;
  row_t pass_r;
  logic [2:0][SUM_W-1:0] sum_r;
  logic [2:0][SUM_W+RED_W-1:0] m_r;
  logic [2:0][RED_W-1:0] r_r;
  elem_t a_k;

  always_comb begin
    case (ksel)
      2'd0:    a_k = acc_r[0];
      2'd1:    a_k = acc_r[1];
      2'd2:    a_k = acc_r[2];
      default: a_k = acc_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.snap) begin
      pass_r <= acc_r;
    end else if (ctl.mac) begin
      pass_r <= pass_in;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [2*ELEM_W-1:0] prod;
    logic [SUM_W:0] qm;
    logic [SUM_W:0] diff;
    assign prod = a_k * pass_r[j];
    assign qm = (SUM_W+1)'(m_r[j][SUM_W+RED_W-1:RECIP_SHIFT]) * (SUM_W+1)'(MODULUS);
    assign diff = {1'b0, sum_r[j]} - qm;

    always_ff @(posedge clk) begin
      if (ctl.mac) begin
        sum_r[j] <= ctl.mac_first ? SUM_W'(prod) : sum_r[j] + SUM_W'(prod);
      end
      if (ctl.red1) begin
        m_r[j] <= sum_r[j] * RECIP;
      end
      if (ctl.red2) begin
        r_r[j] <= diff[RED_W-1:0];
      end
    end
  end

  logic [RED_W-1:0] s0, s1, s2;
  assign s0 = RED_W'(acc_r[0]) + RED_W'(acc_r[1]);
  assign s1 = RED_W'(acc_r[0]) + RED_W'(acc_r[2]);
  assign s2 = {RED_W'(acc_r[0]) << 1} + RED_W'(acc_r[2]);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc_r <= init_row;
    end else if (ctl.red3) begin
      acc_r <= {mod_fix(r_r[2]), mod_fix(r_r[1]), mod_fix(r_r[0])};
    end else if (ctl.base) begin
      // row times [[1,1,2],[1,0,0],[0,1,1]]
      acc_r <= {mod_fix(s2), mod_fix(s1), mod_fix(s0)};
    end
  end

  assign pass_out = pass_r;
  assign acc_row = acc_r;
endmodule
`default_nettype wire

>>> design/recurrence_term_by_matrix_power_top.sv
// Top level: recurrence term by 3x3 matrix power modulo 10007.
//
// Usage:
//   Pulse start with in_term_index while busy is low; that word is taken.
//   busy stays high until the result appears. out_term_value is valid for
//   exactly one cycle, marked by out_valid; the receiver cannot stall, so
//   it must take the word in that cycle.
//   The index n is reduced to n-1 (an index of zero acts as one) and the
//   fixed matrix is raised to that power, MSB first: every exponent bit
//   squares, a set bit also multiplies by the base matrix.
//   Sequence: per exponent bit a snapshot step, multiply-accumulate steps
//   around the ring, the reduction steps RED1, RED2 and RED3, plus a base
//   multiply step (BASE) for a set bit. One item is in flight at a time.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   busy and out_valid; the matrix cells hold no reset state.
`default_nettype none
module recurrence_term_by_matrix_power_top #(
  parameter int unsigned INDEX_BITS = 31
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire [INDEX_BITS-1:0]   in_term_index,
  output logic                   out_valid,
  output logic [13:0]            out_term_value
);
  import rtmp_pkg::*;

  localparam int unsigned BIT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SNAP = 8'b0000_0010,
    S_MAC  = 8'b0000_0100,
    S_RED1 = 8'b0000_1000,
    S_RED2 = 8'b0001_0000,
    S_RED3 = 8'b0010_0000,
    S_BASE = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [INDEX_BITS-1:0] expo_r;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [1:0] t_r, t_nxt;
  logic out_valid_r;
  logic [13:0] out_value_r;
  rtmp_ctl_t ctl;
  logic take;

  row_t pass_w [3];
  row_t acc_w [3];

  assign take = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    bit_nxt = bit_r;
    t_nxt = t_r;
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.init = 1'b1;
          bit_nxt = BIT_W'(INDEX_BITS - 1);
          state_nxt = S_SNAP;
        end
      end
      S_SNAP: begin
        ctl.snap = 1'b1;
        t_nxt = 2'd0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        ctl.mac = 1'b1;
        ctl.mac_first = (t_r == 2'd0);
        t_nxt = t_r + 2'd1;
        if (t_r == 2'd2) state_nxt = S_RED1;
      end
      S_RED1: begin
        ctl.red1 = 1'b1;
        state_nxt = S_RED2;
      end
      S_RED2: begin
        ctl.red2 = 1'b1;
        state_nxt = S_RED3;
      end
      S_RED3: begin
        ctl.red3 = 1'b1;
        if (expo_r[bit_r]) begin
          state_nxt = S_BASE;
        end else if (bit_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r - 1'b1;
          state_nxt = S_SNAP;
        end
      end
      S_BASE: begin
        ctl.base = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r - 1'b1;
          state_nxt = S_SNAP;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    t_r <= t_nxt;
    if (take) begin
      // exponent n-1, index zero saturates to one
      expo_r <= (in_term_index == '0) ? '0 : in_term_index - 1'b1;
    end
    if (state_r == S_DONE) begin
      // first row times start vector (1,1,0)
      out_value_r <= mod_fix(RED_W'(acc_w[0][0]) + RED_W'(acc_w[0][1]));
    end
  end

  // Ring of three row cells; each passes its held row to the cell with the next lower index, wrapping around.
  for (genvar i = 0; i < 3; i++) begin : g_cell
    row_t ident;
    always_comb begin
      ident = '0;
      ident[i] = 14'd1;
    end
    rtmp_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .init_row (ident),
      .ksel     (rot3(2'(i), t_r)),
      .pass_in  (pass_w[(i + 1) % 3]),
      .pass_out (pass_w[i]),
      .acc_row  (acc_w[i])
    );
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_term_value = out_value_r;
endmodule
`default_nettype wire

>>> design/rtmp_checker.sv
// Port-level checker for the recurrence-term block, bound to the top level.
`default_nettype none
module rtmp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [13:0] out_term_value
);
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("word taken but busy not raised");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_term_value < 14'd10007) else $error("result not reduced");
endmodule

bind recurrence_term_by_matrix_power_top rtmp_checker u_rtmp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_term_value (out_term_value)
);
`default_nettype wire

>>> sim/tb.sv
// Testbench for the recurrence-term block: directed and random indexes against a predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INDEX_BITS = 31;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef logic [2:0][2:0][13:0] mat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [INDEX_BITS-1:0] in_term_index = '0;
  wire busy;
  wire out_valid;
  wire [13:0] out_term_value;

  // Expected terms, ring of slots with write and read counts
  logic [13:0] exp_mem [1024];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 0;

  always #4 clk = ~clk;

  recurrence_term_by_matrix_power_top #(.INDEX_BITS(INDEX_BITS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_term_index(in_term_index), .out_valid(out_valid),
    .out_term_value(out_term_value)
  );

  // 3x3 product mod 10007
  function automatic mat_t mat_product(input mat_t a, input mat_t b);
    mat_t r;
    int unsigned acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = 14'(acc % rtmp_pkg::MODULUS);
      end
    end
    return r;
  endfunction

  // Term for index n: first row of base^(n-1) times (1,1,0); n = 0 acts as 1
  function automatic logic [13:0] predict_term(input logic [INDEX_BITS-1:0] n);
    mat_t base_m;
    mat_t pw;
    logic [INDEX_BITS-1:0] expo;
    base_m = '0;
    base_m[0][0] = 14'd1; base_m[0][1] = 14'd1; base_m[0][2] = 14'd2;
    base_m[1][0] = 14'd1; base_m[2][1] = 14'd1; base_m[2][2] = 14'd1;
    pw = '0;
    pw[0][0] = 14'd1; pw[1][1] = 14'd1; pw[2][2] = 14'd1;
    expo = (n == 0) ? '0 : n - 1'b1;
    for (int b = INDEX_BITS - 1; b >= 0; b--) begin
      pw = mat_product(pw, pw);
      if (expo[b]) pw = mat_product(pw, base_m);
    end
    return 14'((32'(pw[0][0]) + 32'(pw[0][1])) % rtmp_pkg::MODULUS);
  endfunction

  // Send one word; sender gap drawn from gap_pct
  task automatic send_index(input logic [INDEX_BITS-1:0] n);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1'b1;
    in_term_index <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    exp_mem[exp_wr[9:0]] = predict_term(n);
    exp_wr++;
    @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_rd == exp_wr) begin
        $error("unexpected term_value %0d", out_term_value);
        fail_count++;
      end else begin
        if (out_term_value !== exp_mem[exp_rd[9:0]]) begin
          $error("term_value expected %0d actual %0d", exp_mem[exp_rd[9:0]],
                 out_term_value);
          fail_count++;
        end
        exp_rd++;
      end
    end
  end

  // Watchdog on cycles with no word accepted either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Directed: extremes, index zero, small indexes and alternating bit patterns
  task automatic test_directed();
    send_index('0);
    send_index(31'd1);
    send_index(31'd2);
    send_index(31'd3);
    send_index(31'd4);
    send_index(31'd5);
    send_index({INDEX_BITS{1'b1}});
    send_index({INDEX_BITS{1'b1}} - 1'b1);
    send_index({1'b1, {(INDEX_BITS-1){1'b0}}});
    send_index({1'b0, {(INDEX_BITS-1){1'b1}}});
    send_index(31'h2AAAAAAA);
    send_index(31'h55555555);
    send_index(31'd10007);
    send_index(31'd10008);
  endtask

  // Random: mix of small, full-width and short-width indexes
  task automatic test_random(input int unsigned count, input int unsigned pct);
    logic [INDEX_BITS-1:0] n;
    gap_pct = pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: n = INDEX_BITS'($urandom_range(64));
        1: n = INDEX_BITS'($urandom) >> $urandom_range(30);
        default: n = INDEX_BITS'($urandom);
      endcase
      send_index(n);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(220, 29);
    test_random(210, 82);
    test_random(210, 0);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
